[src/igsd_pkg.sv]
// ---------------------------------------------------------------------------
// igsd_pkg
// Shared types and constants for the IMU gesture sequence detector.
// ---------------------------------------------------------------------------
package igsd_pkg;

    localparam int HIST_LEN   = 10;
    localparam int HIST_IW    = $clog2(HIST_LEN);
    localparam int CNT_W      = (HIST_IW > 4) ? HIST_IW : 4;
    localparam int SUM_W      = 16 + HIST_IW;
    localparam int SQS_W      = 32 + HIST_IW;
    localparam int D_W        = 2 * SUM_W;
    localparam int SQRT_STEPS = 14;

    // configuration register indexes
    localparam logic [2:0] CFG_BASE_PITCH = 3'd0;
    localparam logic [2:0] CFG_BASE_ROLL  = 3'd1;
    localparam logic [2:0] CFG_ANGLE_THR  = 3'd2;
    localparam logic [2:0] CFG_ACCEL_THR  = 3'd3;
    localparam logic [2:0] CFG_SPEED_THR  = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd5;

    // internal event codes
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_OPEN  = 3'd1;
    localparam logic [2:0] EV_LIFT  = 3'd2;
    localparam logic [2:0] EV_SHAKE = 3'd3;
    localparam logic [2:0] EV_CLOSE = 3'd4;
    localparam logic [2:0] EV_FALSE = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_LIFT  = 3'd0;
    localparam logic [2:0] KIND_SHAKE = 3'd1;
    localparam logic [2:0] KIND_CLOSE = 3'd2;
    localparam logic [2:0] KIND_FALSE = 3'd3;
    localparam logic [2:0] KIND_SEQ   = 3'd4;

    // sequence phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_OPEN = 2'd1;
    localparam logic [1:0] PH_LIFT = 2'd2;

    typedef struct packed {
        logic               load;
        logic               sq_en;
        logic               sq_grp;     // 0 accel, 1 gyro
        logic [1:0]         sq_idx;
        logic               rt_init;
        logic               rt_step;
        logic               save_norm;
        logic               classify;
        logic               sum_en;
        logic [HIST_IW-1:0] sum_idx;
        logic               var_mul;
        logic               var_cmp;
        logic               seq_commit;
    } t_cmd;

    typedef struct packed {
        logic hist_go;
        logic out_free;
    } t_sts;

endpackage

[src/igsd_ctrl.sv]
// ---------------------------------------------------------------------------
// igsd_ctrl
// Sequencer: steps the datapath through squares, roots, rules, variance
// and the sequence update for one sample.
// ---------------------------------------------------------------------------
module igsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  igsd_pkg::t_sts   i_sts,
    output igsd_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQA  = 4'd1;
    localparam logic [3:0] S_RTA  = 4'd2;
    localparam logic [3:0] S_SQG  = 4'd3;
    localparam logic [3:0] S_RTG  = 4'd4;
    localparam logic [3:0] S_CLS  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_VM   = 4'd7;
    localparam logic [3:0] S_VC   = 4'd8;
    localparam logic [3:0] S_SEQ  = 4'd9;

    logic [3:0]                 r_state, n_state;
    logic [igsd_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.sq_idx  = r_cnt[1:0];
        o_cmd.sum_idx = r_cnt[igsd_pkg::HIST_IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SQA;
                    n_cnt = '0;
                end
            end
            S_SQA, S_SQG: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_grp = (r_state == S_SQG);
                o_cmd.save_norm = (r_state == S_SQG) && (r_cnt == '0);
                if (r_cnt == igsd_pkg::CNT_W'(2)) begin
                    n_cnt = '0;
                    n_state = (r_state == S_SQA) ? S_RTA : S_RTG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RTA, S_RTG: begin
                o_cmd.rt_init = (r_cnt == '0);
                o_cmd.rt_step = (r_cnt != '0);
                if (r_cnt == igsd_pkg::CNT_W'(igsd_pkg::SQRT_STEPS)) begin
                    n_cnt = '0;
                    n_state = (r_state == S_RTA) ? S_SQG : S_CLS;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CLS: begin
                o_cmd.classify = 1'b1;
                n_cnt = '0;
                n_state = i_sts.hist_go ? S_SUM : S_SEQ;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                if (r_cnt == igsd_pkg::CNT_W'(igsd_pkg::HIST_LEN - 1)) begin
                    n_cnt = '0;
                    n_state = S_VM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_VM: begin
                o_cmd.var_mul = 1'b1;
                n_state = S_VC;
            end
            S_VC: begin
                o_cmd.var_cmp = 1'b1;
                n_state = S_SEQ;
            end
            S_SEQ: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.seq_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[src/igsd_dp.sv]
// ---------------------------------------------------------------------------
// igsd_dp
// Datapath: sample registers, shared squarer and bit-serial square root,
// rule evaluation, norm history and variance, sequence state, output reg.
// ---------------------------------------------------------------------------
module igsd_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  igsd_pkg::t_cmd      i_cmd,
    output igsd_pkg::t_sts      o_sts,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic signed [12:0]  i_accel_x,
    input  logic signed [12:0]  i_accel_y,
    input  logic signed [12:0]  i_accel_z,
    input  logic signed [13:0]  i_gyro_x,
    input  logic signed [13:0]  i_gyro_y,
    input  logic signed [13:0]  i_gyro_z,
    input  logic signed [12:0]  i_pitch_angle,
    input  logic signed [12:0]  i_roll_angle,
    input  logic [31:0]         i_timestamp_ms,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_event_kind,
    output logic [31:0]         o_elapsed_ms
);

    localparam logic [igsd_pkg::D_W-1:0] SHAKE_THR = igsd_pkg::D_W'(
        (64'd9437184 * igsd_pkg::HIST_LEN * igsd_pkg::HIST_LEN) / 100);

    // configuration
    logic signed [12:0] r_base_pitch, r_base_roll;
    logic [11:0]        r_angle_thr;
    logic [13:0]        r_accel_thr, r_speed_thr;
    logic [15:0]        r_timeout;

    // sample
    logic signed [12:0] r_ax, r_ay, r_az;
    logic signed [13:0] r_gx, r_gy, r_gz;
    logic [12:0]        r_angle;
    logic [31:0]        r_now;

    // squarer / root
    logic [27:0]        r_acc, r_rem, r_root, r_bit;
    logic [15:0]        r_norm;

    // persistent state
    logic [15:0]                  r_prev_speed;
    logic [31:0]                  r_last_fast, r_seq_start, r_last_event;
    logic [15:0]                  r_hist [igsd_pkg::HIST_LEN];
    logic [igsd_pkg::HIST_IW-1:0] r_slot;
    logic [1:0]                   r_phase;

    // per-sample
    logic [2:0]                   r_ev;
    logic [igsd_pkg::SUM_W-1:0]   r_s;
    logic [igsd_pkg::SQS_W-1:0]   r_s2;
    logic [igsd_pkg::D_W-1:0]     r_ns2, r_ss;

    // output register
    logic        r_ov;
    logic [2:0]  r_kind;
    logic [31:0] r_dur;

    function automatic logic signed [13:0] sat_g(input logic signed [13:0] v);
        if (v > 14'sd8000)       sat_g = 14'sd8000;
        else if (v < -14'sd8000) sat_g = -14'sd8000;
        else                     sat_g = v;
    endfunction

    function automatic logic signed [13:0] sat_a(input logic signed [12:0] v);
        logic signed [13:0] w;
        w = 14'(v);
        if (w > 14'sd2880)       sat_a = 14'sd2880;
        else if (w < -14'sd2880) sat_a = -14'sd2880;
        else                     sat_a = w;
    endfunction

    function automatic logic [12:0] abs_diff(input logic signed [13:0] a,
                                             input logic signed [12:0] b);
        logic signed [14:0] d;
        d = 15'(a) - 15'(b);
        abs_diff = d[14] ? 13'(-d) : 13'(d);
    endfunction

    // angle at load
    logic [12:0] w_dp, w_dr;
    assign w_dp = abs_diff(sat_a(i_pitch_angle), r_base_pitch);
    assign w_dr = abs_diff(sat_a(i_roll_angle), r_base_roll);

    // shared squarer
    logic signed [13:0] w_op;
    logic signed [27:0] w_prod;
    always_comb begin
        case ({i_cmd.sq_grp, i_cmd.sq_idx})
            3'b000:  w_op = 14'(r_ax);
            3'b001:  w_op = 14'(r_ay);
            3'b010:  w_op = 14'(r_az);
            3'b100:  w_op = r_gx;
            3'b101:  w_op = r_gy;
            3'b110:  w_op = r_gz;
            default: w_op = '0;
        endcase
    end
    assign w_prod = w_op * w_op;

    logic [27:0] w_trial;
    assign w_trial = r_root + r_bit;

    // rules
    logic [15:0] w_speed;
    logic        w_fast, w_prev_fast, w_false, w_open, w_lift, w_close;
    logic [31:0] w_lf;
    assign w_speed     = r_root[15:0];
    assign w_fast      = w_speed > {2'b00, r_speed_thr};
    assign w_prev_fast = r_prev_speed > {2'b00, r_speed_thr};
    assign w_lf        = w_fast ? r_now : r_last_fast;
    assign w_false     = w_prev_fast && (w_speed < 16'd160) && ((r_now - w_lf) < 32'd100);
    assign w_open      = ({1'b0, r_angle} > {2'b00, r_angle_thr})
                         && ({1'b0, r_norm[14:0]} < {2'b00, r_accel_thr})
                         && (r_norm[15] == 1'b0);
    assign w_lift      = (r_az > 13'sd1228) && (r_angle > 13'd320);
    assign w_close     = (r_angle < 13'd160) && (r_phase == igsd_pkg::PH_LIFT);

    logic [igsd_pkg::HIST_IW-1:0] w_slot, w_slot_nx;
    assign w_slot = ({1'b0, r_slot} >= (igsd_pkg::HIST_IW + 1)'(igsd_pkg::HIST_LEN))
                    ? '0 : r_slot;
    assign w_slot_nx = (w_slot == igsd_pkg::HIST_IW'(igsd_pkg::HIST_LEN - 1))
                       ? '0 : w_slot + 1'b1;

    logic [15:0] w_h;
    logic [31:0] w_hsq;
    logic [igsd_pkg::D_W-1:0] w_ss, w_ns2;
    assign w_h   = r_hist[i_cmd.sum_idx];
    assign w_hsq = w_h * w_h;
    assign w_ss  = r_s * r_s;
    assign w_ns2 = igsd_pkg::D_W'(r_s2) * igsd_pkg::D_W'(igsd_pkg::HIST_LEN);

    // sequence update
    logic [1:0]  w_ph1, w_ph2;
    logic [31:0] w_le1, w_span;
    logic        w_emit;
    logic [2:0]  w_kind;
    logic [31:0] w_dur;
    always_comb begin
        w_ph1  = r_phase;
        w_le1  = r_last_event;
        w_emit = 1'b0;
        w_kind = igsd_pkg::KIND_LIFT;
        w_dur  = '0;
        w_span = r_now - r_seq_start;
        if (r_ev != igsd_pkg::EV_NONE) begin
            w_le1 = r_now;
            case (r_phase)
                igsd_pkg::PH_IDLE: begin
                    if (r_ev != igsd_pkg::EV_OPEN) begin
                        w_emit = 1'b1;
                        case (r_ev)
                            igsd_pkg::EV_LIFT:  w_kind = igsd_pkg::KIND_LIFT;
                            igsd_pkg::EV_SHAKE: w_kind = igsd_pkg::KIND_SHAKE;
                            igsd_pkg::EV_CLOSE: w_kind = igsd_pkg::KIND_CLOSE;
                            default:            w_kind = igsd_pkg::KIND_FALSE;
                        endcase
                    end else begin
                        w_ph1 = igsd_pkg::PH_OPEN;
                    end
                end
                igsd_pkg::PH_OPEN: begin
                    if (r_ev == igsd_pkg::EV_LIFT)  w_ph1 = igsd_pkg::PH_LIFT;
                    else if (w_span > {16'd0, r_timeout}) w_ph1 = igsd_pkg::PH_IDLE;
                end
                igsd_pkg::PH_LIFT: begin
                    if (r_ev == igsd_pkg::EV_CLOSE) begin
                        w_emit = 1'b1;
                        w_kind = igsd_pkg::KIND_SEQ;
                        w_dur  = w_span;
                        w_ph1  = igsd_pkg::PH_IDLE;
                    end else if (w_span > {16'd0, r_timeout}) begin
                        w_ph1 = igsd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    w_ph1 = r_phase;
                end
            endcase
        end
        w_ph2 = w_ph1;
        if (w_ph1 != igsd_pkg::PH_IDLE && (r_now - w_le1) > {16'd0, r_timeout})
            w_ph2 = igsd_pkg::PH_IDLE;
    end

    assign o_sts.hist_go  = !(w_false || w_open || w_lift || w_close);
    assign o_sts.out_free = !r_ov || i_out_ready;

    assign o_out_valid   = r_ov;
    assign o_event_kind  = r_kind;
    assign o_elapsed_ms  = r_dur;

    // control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pitch <= '0;
            r_base_roll  <= '0;
            r_angle_thr  <= 12'd480;
            r_accel_thr  <= 14'd2560;
            r_speed_thr  <= 14'd48;
            r_timeout    <= 16'd2000;
            r_prev_speed <= '0;
            r_last_fast  <= '0;
            r_seq_start  <= '0;
            r_last_event <= '0;
            r_slot       <= '0;
            r_phase      <= igsd_pkg::PH_IDLE;
            r_ov         <= 1'b0;
            for (int i = 0; i < igsd_pkg::HIST_LEN; i++) r_hist[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    igsd_pkg::CFG_BASE_PITCH: r_base_pitch <= i_cfg_data[12:0];
                    igsd_pkg::CFG_BASE_ROLL:  r_base_roll  <= i_cfg_data[12:0];
                    igsd_pkg::CFG_ANGLE_THR:  r_angle_thr  <= i_cfg_data[11:0];
                    igsd_pkg::CFG_ACCEL_THR:  r_accel_thr  <= i_cfg_data[13:0];
                    igsd_pkg::CFG_SPEED_THR:  r_speed_thr  <= i_cfg_data[13:0];
                    igsd_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.classify) begin
                r_prev_speed <= w_speed;
                r_last_fast  <= w_lf;
                if (o_sts.hist_go) begin
                    r_hist[w_slot] <= r_norm;
                    r_slot <= w_slot_nx;
                end
            end
            if (i_cmd.seq_commit) begin
                r_ov         <= w_emit;
                r_last_event <= w_le1;
                r_phase      <= w_ph2;
                if (r_ev == igsd_pkg::EV_OPEN && r_phase == igsd_pkg::PH_IDLE)
                    r_seq_start <= r_now;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= i_accel_x;
            r_ay    <= i_accel_y;
            r_az    <= i_accel_z;
            r_gx    <= sat_g(i_gyro_x);
            r_gy    <= sat_g(i_gyro_y);
            r_gz    <= sat_g(i_gyro_z);
            r_angle <= (w_dp > w_dr) ? w_dp : w_dr;
            r_now   <= i_timestamp_ms;
        end
        if (i_cmd.sq_en)
            r_acc <= (i_cmd.sq_idx == 2'd0) ? 28'(w_prod) : r_acc + 28'(w_prod);
        if (i_cmd.rt_init) begin
            r_rem  <= r_acc;
            r_root <= '0;
            r_bit  <= 28'd1 << 26;
        end else if (i_cmd.rt_step) begin
            if (r_rem >= w_trial) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.save_norm)
            r_norm <= r_root[15:0];
        if (i_cmd.classify) begin
            r_s  <= '0;
            r_s2 <= '0;
            if (w_false)      r_ev <= igsd_pkg::EV_FALSE;
            else if (w_open)  r_ev <= igsd_pkg::EV_OPEN;
            else if (w_lift)  r_ev <= igsd_pkg::EV_LIFT;
            else if (w_close) r_ev <= igsd_pkg::EV_CLOSE;
            else              r_ev <= igsd_pkg::EV_NONE;
        end
        if (i_cmd.sum_en) begin
            r_s  <= r_s + igsd_pkg::SUM_W'(w_h);
            r_s2 <= r_s2 + igsd_pkg::SQS_W'(w_hsq);
        end
        if (i_cmd.var_mul) begin
            r_ss  <= w_ss;
            r_ns2 <= w_ns2;
        end
        if (i_cmd.var_cmp)
            r_ev <= ((r_ns2 - r_ss) > SHAKE_THR) ? igsd_pkg::EV_SHAKE : igsd_pkg::EV_NONE;
        if (i_cmd.seq_commit && w_emit) begin
            r_kind <= w_kind;
            r_dur  <= w_dur;
        end
    end

endmodule

[src/imu_gesture_sequence_detector_core.sv]
// ---------------------------------------------------------------------------
// imu_gesture_sequence_detector_core
// Classifies IMU samples into motion events and tracks the
// open-lift-close gesture sequence.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     i_valid / o_ready         accel, gyro, pitch, roll, timestamp
//  output    o_valid / i_ready         event_kind, elapsed_ms
//  config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  A sample is processed serially: the next sample is accepted only after
//  the current one finishes; a rule that fires ahead of the shake test skips
//  the history sum and variance. The two square roots (one load and 14 steps
//  each) share the single root unit; the history sum adds one entry per cycle.
//  Synchronous active-low reset; no clearing pass is needed.
//  A result held in the output register stalls only the final update step;
//  the next sample is taken as soon as that step completes.
// ---------------------------------------------------------------------------
module imu_gesture_sequence_detector_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [12:0]  i_accel_x,
    input  logic signed [12:0]  i_accel_y,
    input  logic signed [12:0]  i_accel_z,
    input  logic signed [13:0]  i_gyro_x,
    input  logic signed [13:0]  i_gyro_y,
    input  logic signed [13:0]  i_gyro_z,
    input  logic signed [12:0]  i_pitch_angle,
    input  logic signed [12:0]  i_roll_angle,
    input  logic [31:0]         i_timestamp_ms,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_event_kind,
    output logic [31:0]         o_elapsed_ms,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);

    igsd_pkg::t_cmd w_cmd;
    igsd_pkg::t_sts w_sts;

    igsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    igsd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_gyro_x       (i_gyro_x),
        .i_gyro_y       (i_gyro_y),
        .i_gyro_z       (i_gyro_z),
        .i_pitch_angle  (i_pitch_angle),
        .i_roll_angle   (i_roll_angle),
        .i_timestamp_ms (i_timestamp_ms),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_event_kind   (o_event_kind),
        .o_elapsed_ms   (o_elapsed_ms)
    );

endmodule

[verif/igsd_checker.sv]
// ---------------------------------------------------------------------------
// igsd_checker
// Scoreboard for the gesture detector: watches the request and result
// channels and the register port, predicts each event from the accepted
// samples and compares every result field against the oldest prediction.
// ---------------------------------------------------------------------------
module igsd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready_in,
    input  logic signed [12:0]  i_accel_x,
    input  logic signed [12:0]  i_accel_y,
    input  logic signed [12:0]  i_accel_z,
    input  logic signed [13:0]  i_gyro_x,
    input  logic signed [13:0]  i_gyro_y,
    input  logic signed [13:0]  i_gyro_z,
    input  logic signed [12:0]  i_pitch_angle,
    input  logic signed [12:0]  i_roll_angle,
    input  logic [31:0]         i_timestamp_ms,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [2:0]          i_event_kind,
    input  logic [31:0]         i_elapsed_ms,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output int                  o_pending,
    output int                  o_errors,
    output int                  o_events,
    output int                  o_sequences
);

    // register copy
    logic signed [12:0] base_pitch, base_roll;
    logic [11:0]        angle_thr;
    logic [13:0]        accel_thr, speed_thr;
    logic [15:0]        timeout_ms;

    // detector state copy
    logic [15:0] prev_speed;
    logic [31:0] last_fast;
    logic [15:0] norm_hist [igsd_pkg::HIST_LEN];
    int          hist_pos;
    logic [1:0]  phase;
    logic [31:0] seq_start, last_evt;

    logic [2:0]  kind_q [$];
    logic [31:0] dur_q  [$];

    assign o_pending = kind_q.size();

    function automatic logic [31:0] isqrt64(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic int clamp(input int v, input int lim);
        return v < -lim ? -lim : (v > lim ? lim : v);
    endfunction

    function automatic longint unsigned sqr(input int v);
        longint w;
        w = v;
        return longint'(w * w);
    endfunction

    // classify one sample into an internal event code, updating history state
    function automatic logic [2:0] classify_sample(
        input int ax, ay, az, gx, gy, gz, p, r, input logic [31:0] now);
        int                dp, dr;
        logic [31:0]       ang, nrm, spd;
        logic              was_fast;
        longint unsigned   s, s2, lhs, rhs;
        dp = clamp(p, 2880) - int'(base_pitch);
        dr = clamp(r, 2880) - int'(base_roll);
        if (dp < 0) dp = -dp;
        if (dr < 0) dr = -dr;
        ang = dp > dr ? dp : dr;
        nrm = isqrt64(sqr(ax) + sqr(ay) + sqr(az));
        spd = isqrt64(sqr(clamp(gx, 8000)) + sqr(clamp(gy, 8000)) + sqr(clamp(gz, 8000)));
        was_fast = prev_speed > speed_thr;
        if (spd > speed_thr) last_fast = now;
        prev_speed = spd[15:0];
        if (was_fast && spd < 160 && (now - last_fast) < 100) return igsd_pkg::EV_FALSE;
        if (ang > angle_thr && nrm < accel_thr) return igsd_pkg::EV_OPEN;
        if (az > 1228 && ang > 320) return igsd_pkg::EV_LIFT;
        if (ang < 160 && phase == igsd_pkg::PH_LIFT) return igsd_pkg::EV_CLOSE;
        if (hist_pos >= igsd_pkg::HIST_LEN) hist_pos = 0;
        norm_hist[hist_pos] = nrm[15:0];
        hist_pos = (hist_pos + 1) % igsd_pkg::HIST_LEN;
        s = 0;
        s2 = 0;
        for (int i = 0; i < igsd_pkg::HIST_LEN; i++) begin
            s  += norm_hist[i];
            s2 += longint'(norm_hist[i]) * norm_hist[i];
        end
        lhs = 100 * (igsd_pkg::HIST_LEN * s2 - s * s);
        rhs = 64'd9437184 * igsd_pkg::HIST_LEN * igsd_pkg::HIST_LEN;
        return lhs > rhs ? igsd_pkg::EV_SHAKE : igsd_pkg::EV_NONE;
    endfunction

    task automatic predict_event(input logic [31:0] now);
        logic [2:0] ev;
        ev = classify_sample(i_accel_x, i_accel_y, i_accel_z, i_gyro_x, i_gyro_y,
                             i_gyro_z, i_pitch_angle, i_roll_angle, now);
        if (ev != igsd_pkg::EV_NONE) begin
            last_evt = now;
            case (phase)
                igsd_pkg::PH_IDLE: begin
                    if (ev == igsd_pkg::EV_OPEN) begin
                        phase = igsd_pkg::PH_OPEN;
                        seq_start = now;
                    end else begin
                        kind_q.push_back(ev == igsd_pkg::EV_LIFT ? igsd_pkg::KIND_LIFT :
                                         ev == igsd_pkg::EV_SHAKE ? igsd_pkg::KIND_SHAKE :
                                         ev == igsd_pkg::EV_CLOSE ? igsd_pkg::KIND_CLOSE :
                                         igsd_pkg::KIND_FALSE);
                        dur_q.push_back(32'd0);
                    end
                end
                igsd_pkg::PH_OPEN: begin
                    if (ev == igsd_pkg::EV_LIFT) phase = igsd_pkg::PH_LIFT;
                    else if (now - seq_start > timeout_ms) phase = igsd_pkg::PH_IDLE;
                end
                igsd_pkg::PH_LIFT: begin
                    if (ev == igsd_pkg::EV_CLOSE) begin
                        kind_q.push_back(igsd_pkg::KIND_SEQ);
                        dur_q.push_back(now - seq_start);
                        phase = igsd_pkg::PH_IDLE;
                    end else if (now - seq_start > timeout_ms) begin
                        phase = igsd_pkg::PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
        if (phase != igsd_pkg::PH_IDLE && now - last_evt > timeout_ms)
            phase = igsd_pkg::PH_IDLE;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_pitch = 0;
            base_roll  = 0;
            angle_thr  = 480;
            accel_thr  = 2560;
            speed_thr  = 48;
            timeout_ms = 2000;
            prev_speed = 0;
            last_fast  = 0;
            foreach (norm_hist[i]) norm_hist[i] = 0;
            hist_pos   = 0;
            phase      = igsd_pkg::PH_IDLE;
            seq_start  = 0;
            last_evt   = 0;
            kind_q.delete();
            dur_q.delete();
            o_errors    = 0;
            o_events    = 0;
            o_sequences = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    igsd_pkg::CFG_BASE_PITCH: base_pitch = i_cfg_data[12:0];
                    igsd_pkg::CFG_BASE_ROLL:  base_roll  = i_cfg_data[12:0];
                    igsd_pkg::CFG_ANGLE_THR:  angle_thr  = i_cfg_data[11:0];
                    igsd_pkg::CFG_ACCEL_THR:  accel_thr  = i_cfg_data[13:0];
                    igsd_pkg::CFG_SPEED_THR:  speed_thr  = i_cfg_data[13:0];
                    igsd_pkg::CFG_TIMEOUT:    timeout_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (kind_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected event kind=%0d elapsed=%0d", i_event_kind,
                                 i_elapsed_ms);
                end else begin
                    logic [2:0]  k;
                    logic [31:0] d;
                    k = kind_q.pop_front();
                    d = dur_q.pop_front();
                    o_events++;
                    if (k == igsd_pkg::KIND_SEQ) o_sequences++;
                    if (k !== i_event_kind || d !== i_elapsed_ms) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("event mismatch: expected kind=%0d elapsed=%0d, got kind=%0d elapsed=%0d",
                                     k, d, i_event_kind, i_elapsed_ms);
                    end
                end
            end
            // request accepted this edge
            if (i_valid && i_ready_in) predict_event(i_timestamp_ms);
        end
    end

endmodule

[verif/tb_imu_gesture_sequence_detector_core.sv]
// ---------------------------------------------------------------------------
// tb_imu_gesture_sequence_detector_core
// Drives directed and random IMU samples through the gesture detector under
// several register settings, with random idling on both channels; the
// checker predicts and compares every event.
// ---------------------------------------------------------------------------
module tb_imu_gesture_sequence_detector_core;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct {
        logic signed [12:0] ax, ay, az;
        logic signed [13:0] gx, gy, gz;
        logic signed [12:0] p, r;
    } t_sample;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic signed [12:0] i_accel_x = 0, i_accel_y = 0, i_accel_z = 0;
    logic signed [13:0] i_gyro_x = 0, i_gyro_y = 0, i_gyro_z = 0;
    logic signed [12:0] i_pitch_angle = 0, i_roll_angle = 0;
    logic [31:0]        i_timestamp_ms = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic [2:0]         o_event_kind;
    logic [31:0]        o_elapsed_ms;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_idx = 0;
    logic [15:0]        i_cfg_data = 0;

    int          pending, errors, events, sequences;
    int          cycles = 0;
    int          samples = 0;
    bit          no_idle = 0;
    logic [31:0] now_ms = 0;
    int          cur_bp = 0, cur_br = 0, cur_thr = 480, cur_to = 2000;

    always #5 i_clk = ~i_clk;

    imu_gesture_sequence_detector_core u_dut (.*);

    igsd_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready),
        .i_accel_x, .i_accel_y, .i_accel_z, .i_gyro_x, .i_gyro_y, .i_gyro_z,
        .i_pitch_angle, .i_roll_angle, .i_timestamp_ms,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_event_kind(o_event_kind), .i_elapsed_ms(o_elapsed_ms),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_pending(pending), .o_errors(errors), .o_events(events),
        .o_sequences(sequences)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk)
        i_ready <= no_idle || ($urandom_range(99) >= 15);

    task automatic send_sample(input t_sample s, input logic [31:0] ts);
        i_valid        <= 1;
        i_accel_x      <= s.ax;
        i_accel_y      <= s.ay;
        i_accel_z      <= s.az;
        i_gyro_x       <= s.gx;
        i_gyro_y       <= s.gy;
        i_gyro_z       <= s.gz;
        i_pitch_angle  <= s.p;
        i_roll_angle   <= s.r;
        i_timestamp_ms <= ts;
        do @(posedge i_clk); while (!o_ready);
        samples++;
        if (!no_idle && $urandom_range(99) < 15) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end
    endtask

    function automatic t_sample at_rest();
        t_sample s;
        s.ax = 0;  s.ay = 0;  s.az = 13'sd1024;
        s.gx = 0;  s.gy = 0;  s.gz = 0;
        s.p = 13'(cur_bp);
        s.r = 13'(cur_br);
        return s;
    endfunction

    function automatic t_sample noise();
        t_sample s;
        s.ax = 13'($urandom); s.ay = 13'($urandom); s.az = 13'($urandom);
        s.gx = 14'($urandom); s.gy = 14'($urandom); s.gz = 14'($urandom);
        s.p = 13'($urandom);  s.r = 13'($urandom);
        return s;
    endfunction

    // pitch offset from baseline by d, toward the side with more room
    function automatic logic signed [12:0] tilt(input int d);
        return cur_bp >= 0 ? 13'(cur_bp - d) : 13'(cur_bp + d);
    endfunction

    task automatic step_send(input t_sample s, input int lo, input int hi);
        now_ms += $urandom_range(lo, hi);
        send_sample(s, now_ms);
    endtask

    task automatic gesture_run();
        t_sample s;
        int      hi;
        hi = ($urandom_range(9) == 0) ? cur_to + 300 : 400;
        s = at_rest();
        s.p = tilt(cur_thr + int'($urandom_range(1, 120)));
        step_send(s, 1, 60);
        if ($urandom_range(5) == 0) step_send(noise(), 1, 60);
        s = at_rest();
        s.az = 13'($urandom_range(2700, 4095));
        s.p = tilt(int'($urandom_range(321, 700)));
        step_send(s, 1, hi);
        s = at_rest();
        s.p = tilt(int'($urandom_range(0, 159)));
        s.r = 13'(cur_br + int'($urandom_range(0, 100)) - 50);
        step_send(s, 1, hi);
    endtask

    task automatic shake_burst();
        t_sample s;
        repeat ($urandom_range(4, 12)) begin
            s = at_rest();
            s.az = $urandom_range(0, 1) ? 13'sd4095 : 13'sd100;
            step_send(s, 1, 30);
        end
    endtask

    task automatic false_pair();
        t_sample s;
        s = at_rest();
        s.gx = 14'($urandom_range(500, 8191));
        s.gy = 14'($urandom);
        step_send(s, 1, 40);
        s = at_rest();
        s.gz = 14'($urandom_range(0, 150));
        step_send(s, 1, 130);
    endtask

    // write enable stays high across a run of writes; the caller drops it
    task automatic write_reg(input logic [2:0] idx, input int val);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[15:0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_settings(input int bp, br, thr, acc, spd, to);
        drain();
        cur_bp = bp;  cur_br = br;  cur_thr = thr;  cur_to = to;
        write_reg(igsd_pkg::CFG_BASE_PITCH, bp);
        write_reg(igsd_pkg::CFG_BASE_ROLL, br);
        write_reg(igsd_pkg::CFG_ANGLE_THR, thr);
        write_reg(igsd_pkg::CFG_ACCEL_THR, acc);
        write_reg(igsd_pkg::CFG_SPEED_THR, spd);
        write_reg(igsd_pkg::CFG_TIMEOUT, to);
        // indexes past the register list must be ignored
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        i_cfg_we <= 0;
    endtask

    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            no_idle = (i >= n / 3 && i < n / 2);
            if ($urandom_range(49) == 0) now_ms = $urandom;
            k = $urandom_range(99);
            if (k < 45)      gesture_run();
            else if (k < 60) shake_burst();
            else if (k < 72) false_pair();
            else if (k < 85) step_send(at_rest(), 1, 200);
            else             step_send(noise(), 0, 3000);
        end
        no_idle = 0;
    endtask

    initial begin
        t_sample s;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes and wrap of the timestamp
        s.ax = -13'sd4096; s.ay = -13'sd4096; s.az = -13'sd4096;
        s.gx = -14'sd8192; s.gy = -14'sd8192; s.gz = -14'sd8192;
        s.p = -13'sd4096;  s.r = -13'sd4096;
        send_sample(s, 32'd0);
        s.ax = 13'sd4095; s.ay = 13'sd4095; s.az = 13'sd4095;
        s.gx = 14'sd8191; s.gy = 14'sd8191; s.gz = 14'sd8191;
        s.p = 13'sd4095;  s.r = 13'sd4095;
        send_sample(s, 32'hFFFF_FFFF);
        now_ms = 32'hFFFF_FFC0;
        false_pair();
        gesture_run();          // sequence straddling the wrap
        shake_burst();
        s = at_rest();
        s.az = 13'sd3000;
        s.r = 13'sd400;
        step_send(s, 5, 5);     // lift straight from idle
        s = at_rest();
        s.p = 13'sd600;
        step_send(s, 5, 5);     // open, then let it time out
        step_send(at_rest(), 2500, 2600);
        step_send(noise(), 2500, 2600);

        load_settings(2880, -2880, 2880, 8192, 16000, 65535);
        random_phase(70);
        load_settings(-2880, 2880, 0, 0, 0, 0);
        random_phase(70);
        load_settings(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                      $urandom_range(200, 700), $urandom_range(1500, 4000),
                      $urandom_range(20, 300), $urandom_range(200, 3000));
        random_phase(135);
        load_settings(0, 0, 480, 2560, 48, 2000);
        random_phase(135);

        drain();
        $display("covered %0d samples under five register settings", samples);
        $display("checked %0d events, %0d of them completed sequences", events, sequences);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d events outstanding", errors, pending);
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
src/igsd_pkg.sv
src/igsd_ctrl.sv
src/igsd_dp.sv
src/imu_gesture_sequence_detector_core.sv
verif/igsd_checker.sv
verif/tb_imu_gesture_sequence_detector_core.sv
